@@ hdl/ftne_pkg.sv @@
// Package with the shared types and constants of the format text number emitter.
`default_nettype none

package ftne_pkg;

    // One format word: a format character and its argument.
    typedef struct packed {
        logic [7:0]  format_char;
        logic [31:0] argument_value;
    } fmt_in_t;

    // One text word: an emitted character and its end-of-run mark.
    typedef struct packed {
        logic [7:0] out_char;
        logic       last_of_run;
    } fmt_out_t;

    // ASCII codes used by the formatter.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_XU    = 8'h58;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_C     = 8'h63;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_X     = 8'h78;

    // Source of the character placed in the output register.
    typedef enum logic [2:0] {
        SEL_CR,
        SEL_PCT,
        SEL_MINUS,
        SEL_CHAR,
        SEL_ARG,
        SEL_DIGIT
    } ftne_sel_t;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CR,
        ST_PCT,
        ST_LAST_CHAR,
        ST_LAST_PCT,
        ST_LAST_ARG,
        ST_SIGN,
        ST_CONV,
        ST_SKIP,
        ST_DIGIT
    } ftne_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      load;
        logic      load_dec;
        logic      load_hex;
        logic      conv_step;
        logic      dig_shift;
        logic      emit;
        ftne_sel_t sel;
        logic      last;
    } ftne_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_zero;
        logic is_pct;
        logic is_nl;
        logic is_c;
        logic is_dec;
        logic is_hex;
        logic arg_neg;
        logic out_free;
        logic conv_last;
        logic top_zero;
        logic dig_last;
    } ftne_sts_t;

endpackage

`default_nettype wire

@@ hdl/ftne_dpath.sv @@
// Datapath: argument registers, binary to BCD converter, digit shifter and output register.
`default_nettype none

module ftne_dpath
    import ftne_pkg::*;
#(
    parameter int WORD_BITS = 32
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire fmt_in_t   fmt_word,
    input  wire ftne_cmd_t cmd,
    output ftne_sts_t      sts,
    output logic           txt_valid,
    output fmt_out_t       txt_word,
    input  wire logic      txt_stall
);

    // Decimal digits needed for WORD_BITS bits (1233/4096 is just below log10 2).
    localparam int NDIG  = (WORD_BITS * 1233) / 4096 + 1;
    localparam int BCD_W = NDIG * 4;
    localparam int HDIG  = (WORD_BITS + 3) / 4;
    localparam int HEX_W = HDIG * 4;
    localparam int BIT_W = $clog2(WORD_BITS + 1);
    localparam int DIG_W = $clog2(NDIG + 1);

    logic [7:0]           char_reg;
    logic [7:0]           arg_byte_reg;
    logic [WORD_BITS-1:0] mag_reg;
    logic [WORD_BITS-1:0] mag_next;
    logic [BCD_W-1:0]     bcd_reg;
    logic [BCD_W-1:0]     bcd_next;
    logic [BIT_W-1:0]     bit_cnt_reg;
    logic [BIT_W-1:0]     bit_cnt_next;
    logic [DIG_W-1:0]     dig_left_reg;
    logic [DIG_W-1:0]     dig_left_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    fmt_out_t             out_data_reg;
    fmt_out_t             out_data_next;

    logic [WORD_BITS-1:0] arg_w;
    logic [WORD_BITS-1:0] arg_mag;
    logic [HEX_W-1:0]     hex_val;
    logic [BCD_W-1:0]     bcd_adj;
    logic [3:0]           top_nib;
    logic [7:0]           digit_char;
    logic [7:0]           emit_char;

    // Argument at the configured word width and its magnitude for signed decimal.
    assign arg_w   = WORD_BITS'(fmt_word.argument_value);
    assign arg_mag = arg_w[WORD_BITS-1] ? (~arg_w + WORD_BITS'(1)) : arg_w;
    assign hex_val = HEX_W'(arg_w);

    // Decode of the incoming format character.
    always_comb
    begin
        sts.is_zero   = (fmt_word.format_char == CH_NUL);
        sts.is_pct    = (fmt_word.format_char == CH_PCT);
        sts.is_nl     = (fmt_word.format_char == CH_NL);
        sts.is_c      = (fmt_word.format_char == CH_C);
        sts.is_dec    = (fmt_word.format_char == CH_D) || (fmt_word.format_char == CH_I);
        sts.is_hex    = (fmt_word.format_char == CH_X) || (fmt_word.format_char == CH_XU);
        sts.arg_neg   = arg_w[WORD_BITS-1];
        sts.out_free  = !out_valid_reg || !txt_stall;
        sts.conv_last = (bit_cnt_reg == BIT_W'(1));
        sts.top_zero  = (top_nib == 4'd0);
        sts.dig_last  = (dig_left_reg == DIG_W'(1));
    end

    // Add three to every BCD digit of five or more before the next shift.
    always_comb
    begin
        for (int k = 0; k < NDIG; k++)
        begin
            bcd_adj[k*4 +: 4] = (bcd_reg[k*4 +: 4] >= 4'd5) ? (bcd_reg[k*4 +: 4] + 4'd3)
                                                            : bcd_reg[k*4 +: 4];
        end
    end

    // Most significant digit still in the buffer and its ASCII code.
    assign top_nib    = bcd_reg[BCD_W-1 -: 4];
    assign digit_char = (top_nib < 4'd10) ? (CH_ZERO + {4'd0, top_nib})
                                          : (CH_A + {4'd0, top_nib} - 8'd10);

    // Character selection for the output register.
    always_comb
    begin
        unique case (cmd.sel)
            SEL_CR:    emit_char = CH_CR;
            SEL_PCT:   emit_char = CH_PCT;
            SEL_MINUS: emit_char = CH_MINUS;
            SEL_CHAR:  emit_char = char_reg;
            SEL_ARG:   emit_char = arg_byte_reg;
            SEL_DIGIT: emit_char = digit_char;
            default:   emit_char = CH_PCT;
        endcase
    end

    // Conversion registers: loading, one BCD shift a cycle, one digit shift a cycle while dig_shift is given.
    always_comb
    begin
        mag_next      = mag_reg;
        bcd_next      = bcd_reg;
        bit_cnt_next  = bit_cnt_reg;
        dig_left_next = dig_left_reg;
        if (cmd.load_dec)
        begin
            mag_next      = arg_mag;
            bcd_next      = '0;
            bit_cnt_next  = BIT_W'(WORD_BITS);
            dig_left_next = DIG_W'(NDIG);
        end
        else if (cmd.load_hex)
        begin
            bcd_next      = BCD_W'(hex_val) << (BCD_W - HEX_W);
            dig_left_next = DIG_W'(HDIG);
        end
        else if (cmd.conv_step)
        begin
            mag_next     = mag_reg << 1;
            bcd_next     = {bcd_adj[BCD_W-2:0], mag_reg[WORD_BITS-1]};
            bit_cnt_next = bit_cnt_reg - BIT_W'(1);
        end
        else if (cmd.dig_shift)
        begin
            bcd_next      = bcd_reg << 4;
            dig_left_next = dig_left_reg - DIG_W'(1);
        end
    end

    // Output register: filled on emit, emptied when the receiver takes the word.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (cmd.emit)
        begin
            out_valid_next            = 1'b1;
            out_data_next.out_char    = emit_char;
            out_data_next.last_of_run = cmd.last;
        end
        else if (!txt_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_cnt_reg   <= '0;
            dig_left_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            bit_cnt_reg   <= bit_cnt_next;
            dig_left_reg  <= dig_left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            char_reg     <= fmt_word.format_char;
            arg_byte_reg <= fmt_word.argument_value[7:0];
        end
        mag_reg      <= mag_next;
        bcd_reg      <= bcd_next;
        out_data_reg <= out_data_next;
    end

    assign txt_valid = out_valid_reg;
    assign txt_word  = out_data_reg;

endmodule

`default_nettype wire

@@ hdl/ftne_ctrl.sv @@
// Controller: state machine that sequences each format word and holds the pending percent flag.
`default_nettype none

module ftne_ctrl
    import ftne_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      fmt_valid,
    output logic           fmt_stall,
    input  wire ftne_sts_t sts,
    output ftne_cmd_t      cmd
);

    ftne_state_t state_reg;
    ftne_state_t state_next;
    logic        pending_reg;
    logic        pending_next;
    logic        accept;

    // A format word is taken only once the previous one's last word is in the output register.
    assign fmt_stall = (state_reg != ST_IDLE);
    assign accept    = fmt_valid && (state_reg == ST_IDLE);

    // Next state and pending flag.
    always_comb
    begin
        state_next   = state_reg;
        pending_next = pending_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (pending_reg)
                    begin
                        pending_next = 1'b0;
                        priority if (sts.is_c)
                            state_next = ST_LAST_ARG;
                        else if (sts.is_dec)
                            state_next = sts.arg_neg ? ST_SIGN : ST_CONV;
                        else if (sts.is_hex)
                            state_next = ST_SKIP;
                        else if (sts.is_pct || sts.is_zero)
                            state_next = ST_LAST_PCT;
                        else
                            state_next = ST_PCT;
                    end
                    else
                    begin
                        priority if (sts.is_zero)
                            state_next = ST_IDLE;
                        else if (sts.is_pct)
                            pending_next = 1'b1;
                        else if (sts.is_nl)
                            state_next = ST_CR;
                        else
                            state_next = ST_LAST_CHAR;
                    end
                end
            end
            ST_CR, ST_PCT:
            begin
                if (sts.out_free)
                    state_next = ST_LAST_CHAR;
            end
            ST_LAST_CHAR, ST_LAST_PCT, ST_LAST_ARG:
            begin
                if (sts.out_free)
                    state_next = ST_IDLE;
            end
            ST_SIGN:
            begin
                if (sts.out_free)
                    state_next = ST_CONV;
            end
            ST_CONV:
            begin
                if (sts.conv_last)
                    state_next = ST_SKIP;
            end
            ST_SKIP:
            begin
                if (!sts.top_zero || sts.dig_last)
                    state_next = ST_DIGIT;
            end
            ST_DIGIT:
            begin
                if (sts.out_free && sts.dig_last)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb
    begin
        cmd           = '0;
        cmd.sel       = SEL_CHAR;
        cmd.load      = accept;
        cmd.load_dec  = accept && pending_reg && !sts.is_c && sts.is_dec;
        cmd.load_hex  = accept && pending_reg && !sts.is_c && !sts.is_dec && sts.is_hex;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.emit = 1'b0;
            end
            ST_CR:
            begin
                cmd.emit = sts.out_free;
                cmd.sel  = SEL_CR;
            end
            ST_PCT:
            begin
                cmd.emit = sts.out_free;
                cmd.sel  = SEL_PCT;
            end
            ST_LAST_CHAR:
            begin
                cmd.emit = sts.out_free;
                cmd.sel  = SEL_CHAR;
                cmd.last = 1'b1;
            end
            ST_LAST_PCT:
            begin
                cmd.emit = sts.out_free;
                cmd.sel  = SEL_PCT;
                cmd.last = 1'b1;
            end
            ST_LAST_ARG:
            begin
                cmd.emit = sts.out_free;
                cmd.sel  = SEL_ARG;
                cmd.last = 1'b1;
            end
            ST_SIGN:
            begin
                cmd.emit = sts.out_free;
                cmd.sel  = SEL_MINUS;
            end
            ST_CONV:
            begin
                cmd.conv_step = 1'b1;
            end
            ST_SKIP:
            begin
                cmd.dig_shift = sts.top_zero && !sts.dig_last;
            end
            ST_DIGIT:
            begin
                cmd.emit      = sts.out_free;
                cmd.sel       = SEL_DIGIT;
                cmd.last      = sts.dig_last;
                cmd.dig_shift = sts.out_free;
            end
            default:
            begin
                cmd.emit = 1'b0;
            end
        endcase
    end

    // State and pending flag registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            pending_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pending_reg <= pending_next;
        end
    end

    // A word is only written into a free output register.
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> sts.out_free)
        else $error("emit into an occupied output register");

    // The final word of a run returns the controller to idle.
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && cmd.last) |=> (state_reg == ST_IDLE))
        else $error("controller busy after last word of run");

    // A pending conversion is consumed by the very next format word.
    a_pending_used: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && pending_reg) |=> !pending_reg)
        else $error("pending percent not cleared");

    // The pending flag can only be held between format words.
    a_pending_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !pending_reg)
        else $error("pending percent while a word is in progress");

endmodule

`default_nettype wire

@@ hdl/format_text_number_emitter_top.sv @@
// Top level of the format text number emitter: controller and datapath joined.
// Usage:
//   The fmt channel takes one format word per handshake: a format character and a
//   32-bit argument. The txt channel gives one ASCII character per word, with
//   last_of_run set on the final character that a format word produces. A '%'
//   word and an end-of-format word with nothing pending give no text at all.
//   A word is accepted when fmt_valid is high and fmt_stall is low; likewise txt.
// Sequence:
//   One format word is worked on at a time. Plain characters, %c, %% and the
//   '%'-plus-character forms are accepted and then emit their characters in turn.
//   %d and %i are accepted, emit a '-' for a negative value, run the binary to
//   BCD conversion bit by bit over WORD_BITS bits, drop the leading zero digits,
//   find the first digit and emit one digit after another. %x and %X work the
//   same way on nibbles, with no binary to BCD conversion.
// Reset: rst_n clears the pending percent flag, the controller and the output
//   register; no clearing pass follows.
// Stall: the output register holds its word while txt_stall is high, and the
//   controller waits: fmt_stall is high until the run's last word is in txt_word.
`default_nettype none

module format_text_number_emitter_top
    import ftne_pkg::*;
#(
    parameter int WORD_BITS = 32
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     fmt_valid,
    output logic          fmt_stall,
    input  wire fmt_in_t  fmt_word,
    output logic          txt_valid,
    input  wire logic     txt_stall,
    output fmt_out_t      txt_word
);

    ftne_cmd_t cmd;
    ftne_sts_t sts;

    // Sequencing of each format word.
    ftne_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .fmt_valid (fmt_valid),
        .fmt_stall (fmt_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Number conversion and output register.
    ftne_dpath #(
        .WORD_BITS (WORD_BITS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .fmt_word  (fmt_word),
        .cmd       (cmd),
        .sts       (sts),
        .txt_valid (txt_valid),
        .txt_word  (txt_word),
        .txt_stall (txt_stall)
    );

endmodule

`default_nettype wire
